// File: rtl/core/edf_pkg.sv
// Package for the encoder dimension fitter: payload words, configuration
// register map, sequencer states and fixed constants. No dependencies.
package edf_pkg;

  // Input word: one frame size.
  typedef struct packed {
    logic [15:0] frame_width;
    logic [15:0] frame_height;
  } edf_in_t;

  // Result word: fitted even size and whether it is usable.
  typedef struct packed {
    logic [15:0] fitted_width;
    logic [15:0] fitted_height;
    logic        fits;
  } edf_out_t;

  // Configuration register contents.
  typedef struct packed {
    logic [15:0] min_width_limit;
    logic [15:0] min_height_limit;
    logic [15:0] max_width_limit;
    logic [15:0] max_height_limit;
    logic [24:0] macroblock_budget;
  } edf_cfg_t;

  // Request to the shared divider.
  typedef struct packed {
    logic        start;
    logic [15:0] num;
    logic [15:0] den;
  } edf_div_req_t;

  // Register map: byte address 4*i, decoded on paddr[4:2].
  localparam int unsigned CFG_AW = 5;
  localparam logic [2:0] REG_MIN_W  = 3'd0;
  localparam logic [2:0] REG_MIN_H  = 3'd1;
  localparam logic [2:0] REG_MAX_W  = 3'd2;
  localparam logic [2:0] REG_MAX_H  = 3'd3;
  localparam logic [2:0] REG_BUDGET = 3'd4;

  localparam logic [15:0] RST_MIN_DIM = 16'd2;
  localparam logic [15:0] RST_MAX_DIM = 16'd4096;
  localparam logic [24:0] RST_BUDGET  = 25'd0;

  // Smallest dimension that is ever accepted.
  localparam logic [15:0] MIN_DIM = 16'd2;
  // Rounding term for the macroblock count ceil(x / 16).
  localparam logic [16:0] MB_ROUND = 17'd15;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_W_GO,
    ST_DIV_W_WAIT,
    ST_DIV_H_GO,
    ST_DIV_H_WAIT,
    ST_MUL_W,
    ST_MUL_H,
    ST_CAP_H,
    ST_MUL_MB,
    ST_CHECK,
    ST_FINISH
  } edf_state_e;

endpackage

// File: rtl/core/edf_regs.sv
// APB-style configuration registers of the encoder dimension fitter.
// Depends on edf_pkg for the register map and reset values.
module edf_regs
  import edf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output edf_cfg_t          cfg_o
);

  edf_cfg_t cfg_q;
  logic     wr_en;

  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_width_limit   <= RST_MIN_DIM;
      cfg_q.min_height_limit  <= RST_MIN_DIM;
      cfg_q.max_width_limit   <= RST_MAX_DIM;
      cfg_q.max_height_limit  <= RST_MAX_DIM;
      cfg_q.macroblock_budget <= RST_BUDGET;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        REG_MIN_W:  cfg_q.min_width_limit   <= pwdata[15:0];
        REG_MIN_H:  cfg_q.min_height_limit  <= pwdata[15:0];
        REG_MAX_W:  cfg_q.max_width_limit   <= pwdata[15:0];
        REG_MAX_H:  cfg_q.max_height_limit  <= pwdata[15:0];
        REG_BUDGET: cfg_q.macroblock_budget <= pwdata[24:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_MIN_W:  prdata = {16'd0, cfg_q.min_width_limit};
      REG_MIN_H:  prdata = {16'd0, cfg_q.min_height_limit};
      REG_MAX_W:  prdata = {16'd0, cfg_q.max_width_limit};
      REG_MAX_H:  prdata = {16'd0, cfg_q.max_height_limit};
      REG_BUDGET: prdata = {7'd0, cfg_q.macroblock_budget};
      default:    prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/core/edf_div.sv
// Shared restoring divider, one quotient bit per cycle, for the scale ratio
// max * 2^F / dim. Depends on edf_pkg for the request struct.
module edf_div
  import edf_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  edf_div_req_t     req_i,
  output logic             done_o,
  output logic [FRAC_BITS:0] quo_o
);

  localparam int unsigned CW = $clog2(FRAC_BITS + 1);

  logic [16:0]          rem_q;
  logic [FRAC_BITS:0]   quo_q;
  logic [15:0]          den_q;
  logic [CW-1:0]        cnt_q;
  logic                 run_q;
  logic                 done_q;
  logic [17:0]          rem_sh;
  logic                 qbit;
  logic [16:0]          rem_nx;

  // The ratio is only needed up to 1.0, so a numerator that is not below
  // the denominator saturates at once; otherwise the quotient has F bits.
  assign rem_sh = {rem_q, 1'b0};
  assign qbit   = rem_sh >= {2'b00, den_q};
  assign rem_nx = qbit ? 17'(rem_sh - {2'b00, den_q}) : rem_sh[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        if (req_i.num >= req_i.den) begin
          done_q <= 1'b1;
        end else begin
          run_q <= 1'b1;
          cnt_q <= CW'(FRAC_BITS);
        end
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q <= req_i.den;
      rem_q <= {1'b0, req_i.num};
      if (req_i.num >= req_i.den) begin
        quo_q <= {1'b1, {FRAC_BITS{1'b0}}};
      end else begin
        quo_q <= '0;
      end
    end else if (run_q) begin
      rem_q <= rem_nx;
      quo_q <= {quo_q[FRAC_BITS-1:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: rtl/core/edf_mul.sv
// Shared multiplier with a registered product, used for dimension scaling
// and for the macroblock count. Depends on edf_pkg for nothing but style.
module edf_mul
  import edf_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [15:0]           a_i,
  input  logic [FRAC_BITS:0]    b_i,
  output logic [FRAC_BITS+16:0] prod_o
);

  logic [FRAC_BITS+16:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= {{(FRAC_BITS+1){1'b0}}, a_i} * {16'd0, b_i};
    end
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/core/encoder_dimension_fitter_top.sv
// Top level of the encoder dimension fitter: sequencer, search registers and
// result register. Depends on edf_pkg, edf_regs, edf_div and edf_mul.
//
//   channel   direction  handshake            word
//   frame     in         start_i / busy_o     edf_in_t  frame_i
//   result    out        done_o (strobe)      edf_out_t result_o
//   config    in/out     APB psel/penable     32-bit register at 4*index
//
// A frame whose width, height or a maximum is below two gives its result
// in the cycle after it is taken. Otherwise the shared divider forms the
// width ratio and then the height ratio, saturating a ratio at 1.0 without
// iterating when the maximum is not below the dimension. Each trial then
// runs the shared multiplier over width, height and macroblock count; when
// the budget forces a bisection, SEARCH_STEPS further trials follow.
// busy_o stays low for a tiny frame and is otherwise high from the
// accepting edge until the result strobe. Reset is asynchronous and
// returns the sequencer to idle with the registers at their reset values.
// Results are shown for one cycle and cannot be held off.
module encoder_dimension_fitter_top
  import edf_pkg::*;
#(
  parameter int unsigned SCALE_FRAC_BITS = 24,
  parameter int unsigned SEARCH_STEPS    = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  edf_in_t           frame_i,
  output logic              done_o,
  output edf_out_t          result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned FB  = SCALE_FRAC_BITS;
  localparam int unsigned FW  = FB + 1;
  localparam int unsigned PW  = FB + 17;
  localparam int unsigned SCW = $clog2(SEARCH_STEPS + 1);

  edf_cfg_t     cfg;
  edf_div_req_t div_req;
  logic         div_done;
  logic [FB:0]  div_quo;
  logic         mul_en;
  logic [15:0]  mul_a;
  logic [FB:0]  mul_b;
  logic [PW-1:0] prod;

  edf_state_e state_q, state_d;

  logic [15:0]    w_q, h_q;
  logic [FB:0]    fac_q, low_q, high_q;
  logic           search_q;
  logic [SCW-1:0] step_q;
  logic [15:0]    fw_q, fh_q, res_w_q, res_h_q;
  edf_out_t       out_q;
  logic           done_q;

  logic           tiny;
  logic           accept;
  logic [15:0]    scaled;
  logic [16:0]    cw_sum, ch_sum;
  logic           pass;
  logic [FB:0]    next_low, next_high;
  logic [FB+1:0]  mid_sum;
  logic [FB:0]    next_mid;
  logic [15:0]    min_w_eff, min_h_eff;
  logic           fits;

  edf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  edf_div #(.FRAC_BITS(FB)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  edf_mul #(.FRAC_BITS(FB)) u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign accept = start_i && (state_q == ST_IDLE);
  assign tiny   = (frame_i.frame_width < MIN_DIM) || (frame_i.frame_height < MIN_DIM) ||
                  (cfg.max_width_limit < MIN_DIM) || (cfg.max_height_limit < MIN_DIM);

  // Product shifted down by the fraction bits, with bit 0 cleared. The factor
  // never exceeds 1.0, so the scaled value always fits in 16 bits.
  assign scaled = {prod[FB+15:FB+1], 1'b0};

  // Macroblock columns and rows, ceil(x / 16), at most 4096 each.
  assign cw_sum = {1'b0, fw_q} + MB_ROUND;
  assign ch_sum = {1'b0, fh_q} + MB_ROUND;

  // A trial passes when there is no budget or the block count stays within it.
  assign pass = (cfg.macroblock_budget == '0) ||
                (prod <= {{(PW-25){1'b0}}, cfg.macroblock_budget});

  // Bisection bounds after this trial and the next midpoint, floored.
  assign next_low  = pass ? fac_q : low_q;
  assign next_high = pass ? high_q : fac_q;
  assign mid_sum   = {1'b0, next_low} + {1'b0, next_high};
  assign next_mid  = mid_sum[FB+1:1];

  assign min_w_eff = (cfg.min_width_limit < MIN_DIM) ? MIN_DIM : cfg.min_width_limit;
  assign min_h_eff = (cfg.min_height_limit < MIN_DIM) ? MIN_DIM : cfg.min_height_limit;
  assign fits      = (res_w_q >= min_w_eff) && (res_h_q >= min_h_eff);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i && !tiny) begin
          state_d = ST_DIV_W_GO;
        end
      end
      ST_DIV_W_GO:   state_d = ST_DIV_W_WAIT;
      ST_DIV_W_WAIT: if (div_done) state_d = ST_DIV_H_GO;
      ST_DIV_H_GO:   state_d = ST_DIV_H_WAIT;
      ST_DIV_H_WAIT: if (div_done) state_d = ST_MUL_W;
      ST_MUL_W:      state_d = ST_MUL_H;
      ST_MUL_H:      state_d = ST_CAP_H;
      ST_CAP_H:      state_d = ST_MUL_MB;
      ST_MUL_MB:     state_d = ST_CHECK;
      ST_CHECK: begin
        if (!search_q) begin
          state_d = pass ? ST_FINISH : ST_MUL_W;
        end else begin
          state_d = (step_q == SCW'(1)) ? ST_FINISH : ST_MUL_W;
        end
      end
      ST_FINISH:     state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  // Unit controls: divider request and multiplier operands.
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = cfg.max_width_limit;
    div_req.den   = w_q;
    mul_en        = 1'b0;
    mul_a         = w_q;
    mul_b         = fac_q;
    unique case (state_q)
      ST_DIV_W_GO: begin
        div_req.start = 1'b1;
      end
      ST_DIV_H_GO: begin
        div_req.start = 1'b1;
        div_req.num   = cfg.max_height_limit;
        div_req.den   = h_q;
      end
      ST_MUL_W: begin
        mul_en = 1'b1;
      end
      ST_MUL_H: begin
        mul_en = 1'b1;
        mul_a  = h_q;
      end
      ST_MUL_MB: begin
        mul_en = 1'b1;
        mul_a  = {3'd0, cw_sum[16:4]};
        mul_b  = {{(FW-13){1'b0}}, ch_sum[16:4]};
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      search_q <= 1'b0;
      step_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (accept && tiny) || (state_q == ST_FINISH);
      if (state_q == ST_IDLE) begin
        search_q <= 1'b0;
      end else if (state_q == ST_CHECK) begin
        if (!search_q) begin
          if (!pass) begin
            search_q <= 1'b1;
            step_q   <= SCW'(SEARCH_STEPS);
          end
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          w_q <= frame_i.frame_width;
          h_q <= frame_i.frame_height;
          if (tiny) begin
            out_q <= '0;
          end
        end
      end
      ST_DIV_W_WAIT: if (div_done) fac_q <= div_quo;
      ST_DIV_H_WAIT: if (div_done && (div_quo < fac_q)) fac_q <= div_quo;
      ST_MUL_H:      fw_q <= scaled;
      ST_CAP_H:      fh_q <= scaled;
      ST_CHECK: begin
        if (!search_q) begin
          if (pass) begin
            res_w_q <= fw_q;
            res_h_q <= fh_q;
          end else begin
            // Start the bisection over [0, scale]; factor 0 gives a 0x0 size.
            low_q   <= '0;
            high_q  <= fac_q;
            fac_q   <= {1'b0, fac_q[FB:1]};
            res_w_q <= '0;
            res_h_q <= '0;
          end
        end else begin
          low_q  <= next_low;
          high_q <= next_high;
          fac_q  <= next_mid;
          if (pass) begin
            res_w_q <= fw_q;
            res_h_q <= fh_q;
          end
        end
      end
      ST_FINISH: begin
        out_q.fitted_width  <= fits ? res_w_q : 16'd0;
        out_q.fitted_height <= fits ? res_h_q : 16'd0;
        out_q.fits          <= fits;
      end
      default: ;
    endcase
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = out_q;

`ifndef SYNTHESIS
  a_nofit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.fits) |->
      (result_o.fitted_width == 16'd0) && (result_o.fitted_height == 16'd0))
    else $error("rejected size is not reported as zero");

  a_fit_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.fits) |->
      !result_o.fitted_width[0] && !result_o.fitted_height[0] &&
      (result_o.fitted_width >= MIN_DIM) && (result_o.fitted_height >= MIN_DIM))
    else $error("fitted size is odd or below two");

  a_finish_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH) |=> (done_o && !busy_o))
    else $error("finish did not produce exactly the result strobe");

  a_bounds_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (search_q && (state_q == ST_MUL_W)) |-> (low_q <= fac_q) && (fac_q <= high_q))
    else $error("bisection midpoint left its bounds");

  a_busy_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(busy_o)) |-> $fell(busy_o))
    else $error("result strobe while the sequencer is still running");
`endif

endmodule

// File: sim/edf_checker.sv
`timescale 1ns / 100ps
// Result checker for the encoder dimension fitter: tracks register writes,
// predicts every fitted size and compares it with the result port. Needs edf_pkg.
module edf_checker
  import edf_pkg::*;
#(
  parameter int unsigned FRAC  = 24,
  parameter int unsigned STEPS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  edf_in_t           frame_i,
  input  logic              done_i,
  input  edf_out_t          result_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [CFG_AW-1:0] paddr_i,
  input  logic [31:0]       pwdata_i,
  output int unsigned       errors_o,
  output int unsigned       pending_o,
  output int unsigned       results_o,
  output int unsigned       fitted_o,
  output int unsigned       searched_o
);

  localparam logic [63:0] UNITY = 64'd1 << FRAC;

  edf_cfg_t    limits;
  edf_out_t    size_q[$];
  edf_out_t    want;
  bit          hit;
  int unsigned mismatches = 0;
  int unsigned seen       = 0;
  int unsigned fitted     = 0;
  int unsigned searched   = 0;

  // Scaled dimension, floored and made even.
  function automatic logic [63:0] shrink(logic [63:0] dim, logic [63:0] factor);
    return ((dim * factor) >> FRAC) & ~64'd1;
  endfunction

  function automatic bit mb_ok(logic [63:0] w, logic [63:0] h, logic [24:0] budget);
    if (budget == '0) return 1'b1;
    return ((w + 64'd15) / 64'd16) * ((h + 64'd15) / 64'd16) <= {39'd0, budget};
  endfunction

  function automatic edf_out_t fit_frame(edf_in_t f, edf_cfg_t c, output bit used_search);
    logic [63:0] w, h, scale, ratio, fw, fh, lo, hi, mid, minw, minh;
    edf_out_t    r;
    int          i;
    r           = '0;
    used_search = 1'b0;
    w           = {48'd0, f.frame_width};
    h           = {48'd0, f.frame_height};
    if (w < 2 || h < 2 || c.max_width_limit < 2 || c.max_height_limit < 2) return r;
    scale = UNITY;
    ratio = ({48'd0, c.max_width_limit} << FRAC) / w;
    if (ratio < scale) scale = ratio;
    ratio = ({48'd0, c.max_height_limit} << FRAC) / h;
    if (ratio < scale) scale = ratio;
    fw = shrink(w, scale);
    fh = shrink(h, scale);
    if (!mb_ok(fw, fh, c.macroblock_budget)) begin
      // Bisect over [0, scale], keeping the largest factor within budget.
      used_search = 1'b1;
      lo          = '0;
      hi          = scale;
      for (i = 0; i < STEPS; i++) begin
        mid = (lo + hi) >> 1;
        if (mb_ok(shrink(w, mid), shrink(h, mid), c.macroblock_budget)) lo = mid;
        else hi = mid;
      end
      fw = shrink(w, lo);
      fh = shrink(h, lo);
    end
    minw = (c.min_width_limit < 2) ? 64'd2 : {48'd0, c.min_width_limit};
    minh = (c.min_height_limit < 2) ? 64'd2 : {48'd0, c.min_height_limit};
    if (fw < minw || fh < minh) return r;
    r.fitted_width  = fw[15:0];
    r.fitted_height = fh[15:0];
    r.fits          = 1'b1;
    return r;
  endfunction

  task automatic flag(string why);
    if (mismatches < 10) $display("%0t: result %0d: %s", $time, seen, why);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits.min_width_limit   = RST_MIN_DIM;
      limits.min_height_limit  = RST_MIN_DIM;
      limits.max_width_limit   = RST_MAX_DIM;
      limits.max_height_limit  = RST_MAX_DIM;
      limits.macroblock_budget = RST_BUDGET;
    end else begin
      // Results first, so a result cannot be matched with its own frame.
      if (done_i) begin
        if (size_q.size() == 0) begin
          flag($sformatf("unexpected word w=%0d h=%0d fits=%0b",
                         result_i.fitted_width, result_i.fitted_height, result_i.fits));
        end else begin
          want = size_q.pop_front();
          if (result_i.fitted_width !== want.fitted_width ||
              result_i.fitted_height !== want.fitted_height ||
              result_i.fits !== want.fits) begin
            flag($sformatf("expected w=%0d h=%0d fits=%0b, got w=%0d h=%0d fits=%0b",
                           want.fitted_width, want.fitted_height, want.fits,
                           result_i.fitted_width, result_i.fitted_height, result_i.fits));
          end
        end
        seen++;
        if (result_i.fits === 1'b1) fitted++;
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[CFG_AW-1:2])
          REG_MIN_W:  limits.min_width_limit   = pwdata_i[15:0];
          REG_MIN_H:  limits.min_height_limit  = pwdata_i[15:0];
          REG_MAX_W:  limits.max_width_limit   = pwdata_i[15:0];
          REG_MAX_H:  limits.max_height_limit  = pwdata_i[15:0];
          REG_BUDGET: limits.macroblock_budget = pwdata_i[24:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        size_q.push_back(fit_frame(frame_i, limits, hit));
        if (hit) searched++;
      end
    end
    errors_o   <= mismatches + size_q.size();
    pending_o  <= size_q.size();
    results_o  <= seen;
    fitted_o   <= fitted;
    searched_o <= searched;
  end

endmodule

// File: sim/encoder_dimension_fitter_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for the encoder dimension fitter: clock, reset, frame and
// register stimulus, verdict. Needs edf_pkg, edf_checker and the fitter RTL.
module encoder_dimension_fitter_top_tb;
  import edf_pkg::*;

  // Random phases and frames per phase; together with the directed part this
  // comes to roughly twelve hundred frames.
  localparam int unsigned PHASES      = 9;
  localparam int unsigned PER_PHASE   = 130;
  // A stretch this long without an accepted frame or a result strobe means
  // the block is stuck.
  localparam int unsigned STALL_LIMIT = 2000;
  // Address decoded on paddr[4:2] that maps to no register.
  localparam logic [2:0]  REG_SPARE   = 3'd5;

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  edf_in_t           frame_i;
  logic              done_o;
  edf_out_t          result_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int unsigned errors, pending, results, fitted, searched;
  int unsigned n_frames   = 0;
  int unsigned n_settings = 1;
  bit          gaps_on    = 1'b1;

  encoder_dimension_fitter_top u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .frame_i  (frame_i),
    .done_o   (done_o),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // The checker sees the same ports as the block and keeps its own copy of
  // the registers, so it needs nothing from the stimulus side.
  edf_checker u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_i     (busy_o),
    .frame_i    (frame_i),
    .done_i     (done_o),
    .result_i   (result_o),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .pready_i   (pready),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .errors_o   (errors),
    .pending_o  (pending),
    .results_o  (results),
    .fitted_o   (fitted),
    .searched_o (searched)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Lower start and wait until every predicted result has come back and the
  // block is idle. Used before register writes and as a random hold-off.
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy_o);
  endtask

  // One APB write: setup cycle, then access until pready.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Program all limits while the block is idle. The unused upper data bits
  // carry random junk, which the registers must drop, and a write to the
  // spare address must change nothing.
  task automatic set_limits(input logic [15:0] minw, input logic [15:0] minh,
                            input logic [15:0] maxw, input logic [15:0] maxh,
                            input logic [24:0] budget);
    logic [31:0] junk;
    drain();
    junk = $urandom;
    write_reg(REG_MIN_W, {junk[31:16], minw});
    write_reg(REG_MIN_H, {junk[15:0], minh});
    write_reg(REG_MAX_W, {junk[23:8], maxw});
    write_reg(REG_MAX_H, {junk[7:0], junk[31:24], maxh});
    write_reg(REG_BUDGET, {junk[31:25], budget});
    write_reg(REG_SPARE, $urandom);
    n_settings++;
  endtask

  // Offer one frame word and hold it until the block takes it. Start stays
  // high across back-to-back words; it only drops for an idle gap.
  task automatic send_frame(input logic [15:0] w, input logic [15:0] h);
    if (gaps_on && $urandom_range(0, 99) < 11) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    frame_i <= '{frame_width: w, frame_height: h};
    do @(posedge clk_i); while (busy_o);
    n_frames++;
    if (gaps_on && $urandom_range(0, 99) == 0) drain();
  endtask

  // Random dimension around a maximum: mostly sizes that need scaling, with
  // some tiny values and some drawn from the full 16-bit range.
  function automatic logic [15:0] pick_dim(input int unsigned lim);
    int unsigned v;
    case ($urandom_range(0, 9))
      0:       v = $urandom_range(0, 3);
      1, 2:    v = $urandom_range(0, 65535);
      3, 4, 5: v = $urandom_range(lim / 2, lim * 3 + 2);
      default: v = $urandom_range(16, 2048);
    endcase
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  // Watchdog: ends the run with errors when no frame is accepted and no result strobed within STALL_LIMIT.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (start_i && !busy_o) || done_o) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("no word accepted for %0d cycles", STALL_LIMIT);
        $display("encoder_dimension_fitter_top_tb: errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [15:0] minw, minh, maxw, maxh;
    logic [24:0] budget;
    int unsigned phase, k;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    frame_i = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset limits: tiny inputs, the smallest legal frame, the largest frame,
    // frames just inside and just over the maxima, and extreme aspect ratios.
    send_frame(16'd0, 16'd0);
    send_frame(16'd1, 16'd100);
    send_frame(16'd100, 16'd1);
    send_frame(16'd2, 16'd2);
    send_frame(16'hFFFF, 16'hFFFF);
    send_frame(16'd1920, 16'd1080);
    send_frame(16'd4096, 16'd4096);
    send_frame(16'd4097, 16'd4096);
    send_frame(16'hFFFF, 16'd2);
    send_frame(16'd2, 16'hFFFF);

    // Widest maxima, no minimum, and the largest budget the register holds.
    set_limits(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 25'h1FFFFFF);
    send_frame(16'hFFFF, 16'hFFFF);
    send_frame(16'd3, 16'd3);

    // Maxima too small to fit anything.
    set_limits(16'd2, 16'd2, 16'd1, 16'd0, 25'd0);
    send_frame(16'd640, 16'd480);
    send_frame(16'd2, 16'd2);

    // A budget of one macroblock: the search shrinks large frames down to a
    // single block, and for very long frames it collapses to nothing.
    set_limits(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 25'd1);
    send_frame(16'd1920, 16'd1080);
    send_frame(16'hFFFF, 16'hFFFF);
    send_frame(16'hFFFF, 16'd2);

    // Minimum above every possible result, so nothing fits.
    set_limits(16'hFFFF, 16'hFFFF, 16'd4096, 16'd4096, 25'd16777216);
    send_frame(16'hFFFF, 16'hFFFF);
    send_frame(16'd4096, 16'd4096);

    // Random phases. Most budgets are small enough to force the bisection,
    // and the limits occasionally jump to the full register range. One
    // phase runs with start held high throughout.
    for (phase = 0; phase < PHASES; phase++) begin
      minw = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 48));
      minh = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 48));
      maxw = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(16, 4096));
      maxh = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(16, 4096));
      case ($urandom_range(0, 7))
        0:       budget = '0;
        1:       budget = 25'($urandom);
        2, 3, 4: budget = 25'($urandom_range(1, 256));
        default: budget = 25'($urandom_range(256, 16320));
      endcase
      set_limits(minw, minh, maxw, maxh, budget);
      gaps_on = (phase != 4);
      for (k = 0; k < PER_PHASE; k++) begin
        send_frame(pick_dim(maxw), pick_dim(maxh));
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("%0d frames sent under %0d register settings", n_frames, n_settings);
    $display("%0d results checked, %0d fitted, %0d went through the macroblock search",
             results, fitted, searched);
    if (errors == 0) begin
      $display("encoder_dimension_fitter_top_tb: clean");
    end else begin
      $display("encoder_dimension_fitter_top_tb: errors");
    end
    $finish;
  end

endmodule
